@@ sv/jeo_pkg.sv @@
// Shared types and constants for the Josephus elimination order block.
// Holds the microcode word layout, step addresses and datapath widths.
// No dependencies.
package jeo_pkg;

    // default circle capacity
    localparam int DEF_MAX_PEOPLE = 32;
    // a run never yields more words than this
    localparam int RESULT_LIMIT   = 32;

    localparam int CNT_W  = 6;   // people_count, person, remaining
    localparam int STEP_W = 8;   // step_count
    localparam int SUM_W  = 9;   // pos + m + rem - 1 stays below 2**9
    localparam int KBIT_W = 4;   // bit counter for the shift-subtract modulo
    localparam int DIV_W  = SUM_W + KBIT_W + 1;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_FILL,
        OP_MOD_INIT,
        OP_MOD_STEP,
        OP_READ,
        OP_EMIT,
        OP_SHIFT,
        OP_DEC
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_J_LT_REM,
        C_REM_ZERO,
        C_K_NZ,
        C_J1_LT_REM
    } cond_t;

    typedef logic [2:0] step_t;

    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_FILL  = 3'd1;
    localparam step_t STEP_TOP   = 3'd2;
    localparam step_t STEP_MOD   = 3'd3;
    localparam step_t STEP_READ  = 3'd4;
    localparam step_t STEP_EMIT  = 3'd5;
    localparam step_t STEP_SHIFT = 3'd6;
    localparam step_t STEP_DEC   = 3'd7;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic j_lt_rem;
        logic j1_lt_rem;
        logic rem_zero;
        logic k_nz;
    } status_t;

endpackage

@@ sv/jeo_ucode_rom.sv @@
// Microcode store: one control word per step of the elimination program.
// Depends on jeo_pkg.
module jeo_ucode_rom
    import jeo_pkg::*;
(
    input  step_t step,
    output ctrl_t ctrl
);

    // a false condition falls through to the next step
    always_comb
    begin
        unique case (step)
            STEP_IDLE:  ctrl = '{op: OP_LOAD,     cond: C_NO_START,  target: STEP_IDLE};
            STEP_FILL:  ctrl = '{op: OP_FILL,     cond: C_J_LT_REM,  target: STEP_FILL};
            STEP_TOP:   ctrl = '{op: OP_MOD_INIT, cond: C_REM_ZERO,  target: STEP_IDLE};
            STEP_MOD:   ctrl = '{op: OP_MOD_STEP, cond: C_K_NZ,      target: STEP_MOD};
            STEP_READ:  ctrl = '{op: OP_READ,     cond: C_NEVER,     target: STEP_IDLE};
            STEP_EMIT:  ctrl = '{op: OP_EMIT,     cond: C_NEVER,     target: STEP_IDLE};
            STEP_SHIFT: ctrl = '{op: OP_SHIFT,    cond: C_J1_LT_REM, target: STEP_SHIFT};
            STEP_DEC:   ctrl = '{op: OP_DEC,      cond: C_ALWAYS,    target: STEP_TOP};
            default:    ctrl = '{op: OP_LOAD,     cond: C_ALWAYS,    target: STEP_IDLE};
        endcase
    end

endmodule

@@ sv/jeo_sequencer.sv @@
// Step counter with conditional jumps; fetches control words from the ROM.
// Depends on jeo_pkg and jeo_ucode_rom.
module jeo_sequencer
    import jeo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output ctrl_t   ctrl,
    output logic    busy
);

    step_t step_reg;
    step_t step_next;
    logic  take;

    jeo_ucode_rom u_rom
    (
        .step (step_reg),
        .ctrl (ctrl)
    );

    always_comb
    begin
        unique case (ctrl.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_START:  take = !start;
            C_J_LT_REM:  take = status.j_lt_rem;
            C_REM_ZERO:  take = status.rem_zero;
            C_K_NZ:      take = status.k_nz;
            C_J1_LT_REM: take = status.j1_lt_rem;
            default:     take = 1'b0;
        endcase
        step_next = take ? ctrl.target : step_t'(step_reg + 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign busy = (step_reg != STEP_IDLE);

endmodule

@@ sv/jeo_datapath.sv @@
// Datapath: circle list memory, remaining/position registers, modulo by
// shift-subtract and the result register. Driven by the control word.
// Depends on jeo_pkg.
module jeo_datapath
    import jeo_pkg::*;
#(
    parameter int MAX_PEOPLE = DEF_MAX_PEOPLE
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [CNT_W-1:0]   people_count,
    input  logic [STEP_W-1:0]  step_count,
    input  ctrl_t              ctrl,
    output status_t            status,
    output logic [CNT_W-1:0]   person,
    output logic               last,
    output logic               result_valid
);

    localparam int IDX_W     = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
    localparam int MEM_DEPTH = 2 ** IDX_W;
    localparam int RUN_LIM   = (MAX_PEOPLE < RESULT_LIMIT) ? MAX_PEOPLE : RESULT_LIMIT;
    localparam int K_TOP     = SUM_W - 1;

    logic [CNT_W-1:0]  mem [MEM_DEPTH];
    logic [CNT_W-1:0]  rd_data_reg;

    logic [CNT_W-1:0]  rem_reg,  rem_next;
    logic [IDX_W-1:0]  pos_reg,  pos_next;
    logic [CNT_W-1:0]  j_reg,    j_next;
    logic [STEP_W-1:0] m_reg,    m_next;
    logic [SUM_W-1:0]  acc_reg,  acc_next;
    logic [KBIT_W-1:0] k_reg,    k_next;
    logic [CNT_W-1:0]  person_reg, person_next;
    logic              last_reg,   last_next;
    logic              valid_reg,  valid_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [CNT_W-1:0]  wr_data;
    logic [IDX_W-1:0]  rd_addr;

    logic [CNT_W:0]    j_p1;
    logic [CNT_W:0]    j_p2;
    logic [DIV_W-1:0]  divisor;
    logic [CNT_W-1:0]  n_sat;

    assign j_p1    = {1'b0, j_reg} + (CNT_W+1)'(1);
    assign j_p2    = {1'b0, j_reg} + (CNT_W+1)'(2);
    assign divisor = DIV_W'(rem_reg) << k_reg;
    assign n_sat   = (people_count > CNT_W'(RUN_LIM)) ? CNT_W'(RUN_LIM) : people_count;

    assign status.j_lt_rem  = (j_reg < rem_reg);
    assign status.j1_lt_rem = (j_p1 < {1'b0, rem_reg});
    assign status.rem_zero  = (rem_reg == '0);
    assign status.k_nz      = (k_reg != '0);

    always_comb
    begin
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        j_next      = j_reg;
        m_next      = m_reg;
        acc_next    = acc_reg;
        k_next      = k_reg;
        person_next = person_reg;
        last_next   = last_reg;
        valid_next  = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = j_reg[IDX_W-1:0];
        wr_data     = rd_data_reg;
        rd_addr     = j_p1[IDX_W-1:0];

        unique case (ctrl.op)
            OP_LOAD:
            begin
                if (start)
                begin
                    rem_next = n_sat;
                    m_next   = step_count;
                    j_next   = '0;
                    pos_next = '0;
                end
            end
            OP_FILL:
            begin
                // entry k holds person k+1
                if (status.j_lt_rem)
                begin
                    wr_en   = 1'b1;
                    wr_data = j_p1[CNT_W-1:0];
                    j_next  = j_p1[CNT_W-1:0];
                end
            end
            OP_MOD_INIT:
            begin
                acc_next = SUM_W'(pos_reg) + SUM_W'(m_reg) + SUM_W'(rem_reg) - SUM_W'(1);
                k_next   = KBIT_W'(K_TOP);
            end
            OP_MOD_STEP:
            begin
                if (DIV_W'(acc_reg) >= divisor)
                begin
                    acc_next = acc_reg - divisor[SUM_W-1:0];
                end
                if (status.k_nz)
                begin
                    k_next = k_reg - KBIT_W'(1);
                end
            end
            OP_READ:
            begin
                // acc now below rem, so it fits the index
                rd_addr  = acc_reg[IDX_W-1:0];
                pos_next = acc_reg[IDX_W-1:0];
                j_next   = acc_reg[CNT_W-1:0];
            end
            OP_EMIT:
            begin
                person_next = rd_data_reg;
                last_next   = (rem_reg == CNT_W'(1));
                valid_next  = 1'b1;
                rd_addr     = j_p1[IDX_W-1:0];
            end
            OP_SHIFT:
            begin
                // read address runs two entries ahead of the write; the data written was read one entry ahead
                rd_addr = j_p2[IDX_W-1:0];
                if (status.j1_lt_rem)
                begin
                    wr_en  = 1'b1;
                    j_next = j_p1[CNT_W-1:0];
                end
            end
            OP_DEC:
            begin
                rem_next = rem_reg - CNT_W'(1);
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            pos_reg   <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        acc_reg    <= acc_next;
        person_reg <= person_next;
        last_reg   <= last_next;
    end

    assign person       = person_reg;
    assign last         = last_reg;
    assign result_valid = valid_reg;

endmodule

@@ sv/josephus_elimination_order.sv @@
// Top level of the Josephus elimination order block: sequencer plus datapath.
// Depends on jeo_pkg, jeo_sequencer, jeo_datapath.
//
//  channel  | ports                        | handshake
//  ---------+------------------------------+------------------------------
//  input    | people_count, step_count     | taken when start & !busy
//  result   | person, last                 | one cycle, marked by result_valid
//
// The run time is set by the shift-subtract modulo (9 steps) and by the
// one-entry-a-cycle list shift through the one-read, one-write memory, which
// moves down the entries after each removal. busy stays high for the run.
// Reset clears the step counter and counters; the list needs no clearing.
// Result words cannot be held off: each is valid for its single cycle only.
module josephus_elimination_order
    import jeo_pkg::*;
#(
    parameter int MAX_PEOPLE = DEF_MAX_PEOPLE
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CNT_W-1:0]  people_count,
    input  logic [STEP_W-1:0] step_count,
    output logic [CNT_W-1:0]  person,
    output logic              last,
    output logic              result_valid
);

    ctrl_t   ctrl;
    status_t status;

    jeo_sequencer u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    jeo_datapath #(
        .MAX_PEOPLE (MAX_PEOPLE)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .people_count (people_count),
        .step_count   (step_count),
        .ctrl         (ctrl),
        .status       (status),
        .person       (person),
        .last         (last),
        .result_valid (result_valid)
    );

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for josephus_elimination_order: drives circle sizes and
// step counts, predicts each removal order and checks every result word.
// Depends on jeo_pkg and the josephus_elimination_order RTL.
module testbench;
    import jeo_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 1100;
    localparam int RANDOM_RUNS = 340;

    typedef struct packed {
        logic [CNT_W-1:0]  people;
        logic [STEP_W-1:0] step;
    } circle_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] person;
        logic             last;
    } removal_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [CNT_W-1:0]  people_count = '0;
    logic [STEP_W-1:0] step_count = '0;
    logic [CNT_W-1:0]  person;
    logic              last;
    logic              result_valid;

    circle_cmd_t pending_circles[$];
    removal_t    expected_removals[$];
    int          total_runs;
    int          issued_runs = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          word_taken = 1'b0;

    josephus_elimination_order i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .people_count (people_count),
        .step_count   (step_count),
        .person       (person),
        .last         (last),
        .result_valid (result_valid)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Removal order for one run: list of 1..n, position wraps mod remaining count.
    task automatic josephus_order(input logic [CNT_W-1:0] people_in,
                                  input logic [STEP_W-1:0] step_in);
        logic [CNT_W-1:0] circle[$];
        int               n;
        int               pos;
        removal_t         word;
        n = int'(people_in);
        if (n > DEF_MAX_PEOPLE)
            n = DEF_MAX_PEOPLE;
        if (n > RESULT_LIMIT)
            n = RESULT_LIMIT;
        for (int k = 0; k < n; k++)
            circle.push_back(CNT_W'(k + 1));
        pos = 0;
        for (int i = n; i >= 1; i--)
        begin
            pos = (pos + int'(step_in) + i - 1) % i;
            word.person = circle[pos];
            word.last   = (i == 1);
            circle.delete(pos);
            expected_removals.push_back(word);
        end
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic add_circle(input int people, input int step);
        circle_cmd_t cmd;
        cmd.people = CNT_W'(people);
        cmd.step   = STEP_W'(step);
        pending_circles.push_back(cmd);
    endtask

    // driver: a new word is offered only once the previous one was taken
    always @(negedge clk)
    begin : driver
        int          idle_pct;
        circle_cmd_t cmd;
        if (rst_n && !(start && !word_taken))
        begin
            if (issued_runs < total_runs / 3)
                idle_pct = 35;
            else if (issued_runs < 2 * total_runs / 3)
                idle_pct = 73;
            else
                idle_pct = 0;
            if (pending_circles.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                cmd = pending_circles.pop_front();
                issued_runs++;
                people_count <= cmd.people;
                step_count   <= cmd.step;
                start        <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        removal_t want;
        bit       moved;
        moved = 1'b0;
        if (!rst_n)
            word_taken <= 1'b0;
        else
        begin
            if (result_valid)
            begin
                moved = 1'b1;
                if (expected_removals.size() == 0)
                    flag_error($sformatf("unexpected word: person %0d last %0b", person, last));
                else
                begin
                    want = expected_removals.pop_front();
                    if (person !== want.person || last !== want.last)
                        flag_error($sformatf("expected person %0d last %0b, got %0d %0b",
                                             want.person, want.last, person, last));
                end
            end
            if (start && !busy)
            begin
                moved = 1'b1;
                josephus_order(people_count, step_count);
            end
            word_taken <= start && !busy;
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int r;
        int people;
        int step;
        // edges: single person, empty circle, full and oversized circles, zero step
        add_circle(1, 1);
        add_circle(1, 255);
        add_circle(1, 0);
        add_circle(0, 5);
        add_circle(0, 0);
        add_circle(32, 1);
        add_circle(32, 255);
        add_circle(32, 0);
        add_circle(32, 3);
        add_circle(33, 7);
        add_circle(63, 255);
        add_circle(63, 0);
        add_circle(2, 1);
        add_circle(2, 2);
        add_circle(7, 3);
        add_circle(41, 3);
        add_circle(5, 0);
        add_circle(10, 128);
        add_circle(31, 2);
        add_circle(16, 127);
        add_circle(42, 170);
        add_circle(21, 85);
        for (int k = 0; k < RANDOM_RUNS; k++)
        begin
            r = $urandom_range(99);
            if (r < 5)
                people = 0;
            else if (r < 10)
                people = $urandom_range(63, 33);
            else
                people = $urandom_range(32, 1);
            r = $urandom_range(99);
            if (r < 8)
                step = 0;
            else if (r < 16)
                step = 255;
            else if (r < 50)
                step = $urandom_range(8, 1);
            else
                step = $urandom_range(255);
            add_circle(people, step);
        end
        total_runs = pending_circles.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_circles.size() != 0 || start)
            @(posedge clk);
        while (expected_removals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0 && expected_removals.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
